[hw/rtl/cmdtok_pkg.sv]
// Shared types, codes and byte constants for the command line tokenizer.
package cmdtok_pkg;

    // Parse phase of the current line
    typedef enum logic [3:0] {
        PH_LEAD,
        PH_CMD,
        PH_GAP,
        PH_ARG,
        PH_INLEAD,
        PH_INFILE,
        PH_OUTLEAD,
        PH_OUTFILE,
        PH_ERR
    } t_phase;

    // Token kinds
    localparam logic [2:0] KIND_SEP    = 3'd0;
    localparam logic [2:0] KIND_CMD    = 3'd1;
    localparam logic [2:0] KIND_ARG    = 3'd2;
    localparam logic [2:0] KIND_INFILE = 3'd3;
    localparam logic [2:0] KIND_OUTFILE = 3'd4;

    // Parse status codes
    localparam logic [2:0] ST_OK         = 3'd0;
    localparam logic [2:0] ST_EMPTY      = 3'd1;
    localparam logic [2:0] ST_REDIR_PIPE = 3'd2;
    localparam logic [2:0] ST_SECOND_IN  = 3'd3;
    localparam logic [2:0] ST_SECOND_OUT = 3'd4;
    localparam logic [2:0] ST_BG_PIPE    = 3'd5;

    // Unsupported feature codes
    localparam logic [2:0] UNS_NONE      = 3'd0;
    localparam logic [2:0] UNS_QUOTE     = 3'd1;
    localparam logic [2:0] UNS_WILDCARD  = 3'd2;
    localparam logic [2:0] UNS_TILDE     = 3'd3;
    localparam logic [2:0] UNS_BACKSLASH = 3'd4;

    // Byte values
    localparam logic [7:0] CH_SPACE     = 8'h20;
    localparam logic [7:0] CH_LT        = 8'h3C;
    localparam logic [7:0] CH_GT        = 8'h3E;
    localparam logic [7:0] CH_AMP       = 8'h26;
    localparam logic [7:0] CH_DQUOTE    = 8'h22;
    localparam logic [7:0] CH_SQUOTE    = 8'h27;
    localparam logic [7:0] CH_STAR      = 8'h2A;
    localparam logic [7:0] CH_QMARK     = 8'h3F;
    localparam logic [7:0] CH_TILDE     = 8'h7E;
    localparam logic [7:0] CH_BACKSLASH = 8'h5C;

    // Per-line parse state
    typedef struct packed {
        t_phase     phase;
        logic       in_flag;
        logic       out_flag;
        logic       bg_flag;
        logic [2:0] err;
        logic [2:0] unsup;
        logic       nonspace;
    } t_line_state;

    localparam t_line_state LINE_CLEAR = '{
        phase:    PH_LEAD,
        in_flag:  1'b0,
        out_flag: 1'b0,
        bg_flag:  1'b0,
        err:      ST_OK,
        unsup:    UNS_NONE,
        nonspace: 1'b0
    };

    // One result item
    typedef struct packed {
        logic [7:0] echo_byte;
        logic [2:0] token_kind;
        logic       token_start;
        logic       line_done;
        logic [2:0] parse_status;
        logic       in_redirected;
        logic       out_redirected;
        logic       run_background;
        logic [2:0] unsupported_code;
    } t_result;

endpackage

[hw/rtl/cmdtok_step.sv]
// Combinational per-byte tokenizer step: next line state and result item.
module cmdtok_step
    import cmdtok_pkg::*;
(
    input  t_line_state i_state,
    input  logic [7:0]  i_char_byte,
    input  logic        i_byte_valid,
    input  logic        i_line_end,
    input  logic        i_piped_mode,
    output t_line_state o_state_next,
    output t_result     o_result
);

    logic        is_space;
    logic        is_lt;
    logic        is_gt;
    logic        is_amp;
    logic        is_sep;
    logic        take_gap;
    logic        take_word;
    logic [2:0]  w_kind;
    logic        w_start;
    t_phase      w_phase;
    t_line_state upd;

    assign is_space = (i_char_byte == CH_SPACE);
    assign is_lt    = (i_char_byte == CH_LT);
    assign is_gt    = (i_char_byte == CH_GT);
    assign is_amp   = (i_char_byte == CH_AMP);
    assign is_sep   = is_space | is_lt | is_gt | is_amp;

    // Decide how this byte is handled in the current phase
    always_comb begin
        take_gap  = 1'b0;
        take_word = 1'b0;
        w_kind    = KIND_SEP;
        w_start   = 1'b0;
        w_phase   = i_state.phase;
        if (i_byte_valid) begin
            unique case (i_state.phase)
                PH_LEAD: begin
                    if (is_sep && !is_space) begin
                        take_gap = 1'b1;
                    end else if (!is_space) begin
                        take_word = 1'b1;
                        w_kind    = KIND_CMD;
                        w_start   = 1'b1;
                        w_phase   = PH_CMD;
                    end
                end
                PH_CMD, PH_ARG, PH_INFILE, PH_OUTFILE: begin
                    if (is_sep) begin
                        take_gap = 1'b1;
                    end else begin
                        take_word = 1'b1;
                        w_phase   = i_state.phase;
                        unique case (i_state.phase)
                            PH_CMD:    w_kind = KIND_CMD;
                            PH_ARG:    w_kind = KIND_ARG;
                            PH_INFILE: w_kind = KIND_INFILE;
                            default:   w_kind = KIND_OUTFILE;
                        endcase
                    end
                end
                PH_INLEAD, PH_OUTLEAD: begin
                    if (is_sep && !is_space) begin
                        take_gap = 1'b1;
                    end else if (!is_space) begin
                        take_word = 1'b1;
                        w_start   = 1'b1;
                        if (i_state.phase == PH_INLEAD) begin
                            w_kind  = KIND_INFILE;
                            w_phase = PH_INFILE;
                        end else begin
                            w_kind  = KIND_OUTFILE;
                            w_phase = PH_OUTFILE;
                        end
                    end
                end
                PH_ERR: begin
                end
                default: begin
                    take_gap = 1'b1;
                end
            endcase
        end
    end

    // Next line state
    always_comb begin
        upd = i_state;
        if (i_byte_valid) begin
            case (i_char_byte)
                CH_DQUOTE, CH_SQUOTE: upd.unsup = UNS_QUOTE;
                CH_STAR, CH_QMARK:    upd.unsup = UNS_WILDCARD;
                CH_TILDE:             upd.unsup = UNS_TILDE;
                CH_BACKSLASH:         upd.unsup = UNS_BACKSLASH;
                default:              upd.unsup = i_state.unsup;
            endcase
            if (!is_space) begin
                upd.nonspace = 1'b1;
            end
        end
        if (take_word) begin
            upd.phase = w_phase;
        end
        if (take_gap) begin
            if (is_space) begin
                upd.phase = PH_GAP;
            end else if (is_lt) begin
                if (i_piped_mode) begin
                    upd.err   = ST_REDIR_PIPE;
                    upd.phase = PH_ERR;
                end else if (i_state.in_flag) begin
                    upd.err   = ST_SECOND_IN;
                    upd.phase = PH_ERR;
                end else begin
                    upd.in_flag = 1'b1;
                    upd.phase   = PH_INLEAD;
                end
            end else if (is_gt) begin
                if (i_piped_mode) begin
                    upd.err   = ST_REDIR_PIPE;
                    upd.phase = PH_ERR;
                end else if (i_state.out_flag) begin
                    upd.err   = ST_SECOND_OUT;
                    upd.phase = PH_ERR;
                end else begin
                    upd.out_flag = 1'b1;
                    upd.phase    = PH_OUTLEAD;
                end
            end else if (is_amp) begin
                if (i_piped_mode) begin
                    upd.err   = ST_BG_PIPE;
                    upd.phase = PH_ERR;
                end else begin
                    upd.bg_flag = 1'b1;
                    upd.phase   = PH_GAP;
                end
            end else begin
                upd.phase = PH_ARG;
            end
        end
    end

    assign o_state_next = i_line_end ? LINE_CLEAR : upd;

    // Result item
    always_comb begin
        o_result           = '0;
        o_result.echo_byte = i_byte_valid ? i_char_byte : 8'd0;
        if (take_word) begin
            o_result.token_kind  = w_kind;
            o_result.token_start = w_start;
        end else if (take_gap && !is_sep) begin
            o_result.token_kind  = KIND_ARG;
            o_result.token_start = 1'b1;
        end
        o_result.line_done = i_line_end;
        if (i_line_end) begin
            o_result.parse_status     = (upd.err == ST_OK && !upd.nonspace) ? ST_EMPTY
                                                                            : upd.err;
            o_result.in_redirected    = upd.in_flag;
            o_result.out_redirected   = upd.out_flag;
            o_result.run_background   = upd.bg_flag;
            o_result.unsupported_code = upd.unsup;
        end
    end

endmodule

[hw/rtl/command_line_tokenizer_top.sv]
// Top level of the command line tokenizer: item registers, line state, config.
//
//  channel  | handshake                | payload
//  ---------+--------------------------+---------------------------------------------
//  in       | i_in_valid / o_in_stall  | i_char_byte, i_byte_valid, i_line_end
//  out      | o_out_valid / i_out_stall| o_echo_byte, o_token_kind, ... o_unsupported_code
//  config   | i_cfg_we                 | i_cfg_wdata (piped_mode)
//
//  Each item is held in the input register, then passes through the step logic into
//  the result register. One item per cycle sustained while the output does not stall;
//  the line state register closes its loop through the step logic.
//  Reset (i_rst_n low, synchronous) empties both registers and clears line state and
//  piped_mode. A stall on the output holds the result and the input register; the input
//  side stalls only when the input register is full and cannot advance.
module command_line_tokenizer_top
    import cmdtok_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic       i_cfg_wdata,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic [7:0] i_char_byte,
    input  logic       i_byte_valid,
    input  logic       i_line_end,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic [7:0] o_echo_byte,
    output logic [2:0] o_token_kind,
    output logic       o_token_start,
    output logic       o_line_done,
    output logic [2:0] o_parse_status,
    output logic       o_in_redirected,
    output logic       o_out_redirected,
    output logic       o_run_background,
    output logic [2:0] o_unsupported_code
);

    logic        r_piped_mode;
    t_line_state r_state;
    logic        r_in_vld;
    logic [7:0]  r_char_byte;
    logic        r_byte_valid;
    logic        r_line_end;
    logic        r_out_vld;
    t_result     r_result;

    t_line_state n_state;
    t_result     n_result;
    logic        out_free;
    logic        advance;
    logic        in_accept;

    // Advance the input item into the result register when that register is free
    assign out_free   = !r_out_vld || !i_out_stall;
    assign advance    = r_in_vld && out_free;
    assign o_in_stall = r_in_vld && !out_free;
    assign in_accept  = i_in_valid && !o_in_stall;

    cmdtok_step u_step (
        .i_state      (r_state),
        .i_char_byte  (r_char_byte),
        .i_byte_valid (r_byte_valid),
        .i_line_end   (r_line_end),
        .i_piped_mode (r_piped_mode),
        .o_state_next (n_state),
        .o_result     (n_result)
    );

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_piped_mode <= 1'b0;
            r_state      <= LINE_CLEAR;
            r_in_vld     <= 1'b0;
            r_out_vld    <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_piped_mode <= i_cfg_wdata;
            end
            if (advance) begin
                r_state <= n_state;
            end
            if (in_accept) begin
                r_in_vld <= 1'b1;
            end else if (advance) begin
                r_in_vld <= 1'b0;
            end
            if (advance) begin
                r_out_vld <= 1'b1;
            end else if (out_free) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // Payload: capture on accept, hold otherwise
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_char_byte  <= i_char_byte;
            r_byte_valid <= i_byte_valid;
            r_line_end   <= i_line_end;
        end
        if (advance) begin
            r_result <= n_result;
        end
    end

    assign o_out_valid        = r_out_vld;
    assign o_echo_byte        = r_result.echo_byte;
    assign o_token_kind       = r_result.token_kind;
    assign o_token_start      = r_result.token_start;
    assign o_line_done        = r_result.line_done;
    assign o_parse_status     = r_result.parse_status;
    assign o_in_redirected    = r_result.in_redirected;
    assign o_out_redirected   = r_result.out_redirected;
    assign o_run_background   = r_result.run_background;
    assign o_unsupported_code = r_result.unsupported_code;

endmodule

[sim/command_line_tokenizer_top_test.sv]
// Command line tokenizer self-checking bench: directed/random lines, line parser, scoreboard.
`timescale 1ns / 1ps

module command_line_tokenizer_top_test
    import cmdtok_pkg::*;
();

    // Cycles with no item moving on either channel before the run is declared hung
    localparam int STUCK_LIMIT = 3000;
    // Counted items per random phase
    localparam int PHASE_ITEMS = 170;

    // One input item as the sender sees it
    typedef struct packed {
        logic [7:0] ch;
        logic       vld;
        logic       last;
    } t_byte_item;

    // ------------------------------------------------------------------
    // Clock, reset and the signals around the block
    // ------------------------------------------------------------------
    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       cfg_we = 1'b0;
    logic       cfg_wdata = 1'b0;
    logic       in_valid = 1'b0;
    logic       in_stall;
    logic [7:0] char_byte = 8'h00;
    logic       byte_valid = 1'b0;
    logic       line_end = 1'b0;
    logic       out_valid;
    logic       out_stall = 1'b1;
    logic [7:0] echo_byte;
    logic [2:0] token_kind;
    logic       token_start;
    logic       line_done;
    logic [2:0] parse_status;
    logic       in_redirected;
    logic       out_redirected;
    logic       run_background;
    logic [2:0] unsupported_code;

    command_line_tokenizer_top u_top (
        .i_clk             (clk),
        .i_rst_n           (rst_n),
        .i_cfg_we          (cfg_we),
        .i_cfg_wdata       (cfg_wdata),
        .i_in_valid        (in_valid),
        .o_in_stall        (in_stall),
        .i_char_byte       (char_byte),
        .i_byte_valid      (byte_valid),
        .i_line_end        (line_end),
        .o_out_valid       (out_valid),
        .i_out_stall       (out_stall),
        .o_echo_byte       (echo_byte),
        .o_token_kind      (token_kind),
        .o_token_start     (token_start),
        .o_line_done       (line_done),
        .o_parse_status    (parse_status),
        .o_in_redirected   (in_redirected),
        .o_out_redirected  (out_redirected),
        .o_run_background  (run_background),
        .o_unsupported_code(unsupported_code)
    );

    initial begin
        forever #5 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Shared test state
    // ------------------------------------------------------------------
    t_byte_item  pending_items[$];     // items waiting for the driver
    t_result     expected_results[$];  // predicted results, oldest first
    logic [7:0]  line_text[$];         // bytes of the line being built
    t_byte_item  drv_item;             // item currently offered to the block
    t_result     seen_result;

    int unsigned send_idle_pct = 30;
    int unsigned recv_idle_pct = 30;
    int          stim_items = 0;       // items queued, ignored ones excluded
    int          ignored_items = 0;
    int          results_checked = 0;
    int          mismatch_count = 0;
    int          stuck_cycles = 0;

    // Own copy of the line state and the piping register
    logic        piping = 1'b0;
    t_phase      ln_phase = PH_LEAD;
    logic        ln_in = 1'b0;
    logic        ln_out = 1'b0;
    logic        ln_bg = 1'b0;
    logic [2:0]  ln_err = ST_OK;
    logic [2:0]  ln_unsup = UNS_NONE;
    logic        ln_nonspace = 1'b0;

    // Coverage tallies for the closing summary
    int          lines_seen = 0;
    int          piped_lines = 0;
    int          line_outcomes[0:7];

    // ------------------------------------------------------------------
    // Line parser: predicts one result per accepted item
    // ------------------------------------------------------------------
    function automatic logic is_sep(input logic [7:0] c);
        return c == CH_SPACE || c == CH_LT || c == CH_GT || c == CH_AMP;
    endfunction

    // Byte seen between tokens: separators move the phase or raise an error,
    // anything else opens an argument.
    function automatic void between_tokens(input logic [7:0] c, output logic [2:0] kind,
                                           output logic start);
        kind  = KIND_SEP;
        start = 1'b0;
        case (c)
            CH_SPACE: ln_phase = PH_GAP;
            CH_LT: begin
                if (piping) begin
                    ln_err   = ST_REDIR_PIPE;
                    ln_phase = PH_ERR;
                end else if (ln_in) begin
                    ln_err   = ST_SECOND_IN;
                    ln_phase = PH_ERR;
                end else begin
                    ln_in    = 1'b1;
                    ln_phase = PH_INLEAD;
                end
            end
            CH_GT: begin
                if (piping) begin
                    ln_err   = ST_REDIR_PIPE;
                    ln_phase = PH_ERR;
                end else if (ln_out) begin
                    ln_err   = ST_SECOND_OUT;
                    ln_phase = PH_ERR;
                end else begin
                    ln_out   = 1'b1;
                    ln_phase = PH_OUTLEAD;
                end
            end
            CH_AMP: begin
                if (piping) begin
                    ln_err   = ST_BG_PIPE;
                    ln_phase = PH_ERR;
                end else begin
                    ln_bg    = 1'b1;
                    ln_phase = PH_GAP;
                end
            end
            default: begin
                kind     = KIND_ARG;
                start    = 1'b1;
                ln_phase = PH_ARG;
            end
        endcase
    endfunction

    // Carry on a word, or open one after the spaces that follow a redirect
    function automatic void continue_word(input logic [7:0] c, input logic [2:0] kind_here,
                                          input t_phase next_phase, input logic starting,
                                          output logic [2:0] kind, output logic start);
        if (starting && c == CH_SPACE) begin
            kind  = KIND_SEP;
            start = 1'b0;
        end else if (is_sep(c)) begin
            between_tokens(c, kind, start);
        end else begin
            kind     = kind_here;
            start    = starting;
            ln_phase = next_phase;
        end
    endfunction

    function automatic t_result predict_token(input t_byte_item it);
        t_result    r;
        logic [2:0] kind;
        logic       start;
        kind  = KIND_SEP;
        start = 1'b0;
        if (it.vld) begin
            case (it.ch)
                CH_DQUOTE, CH_SQUOTE: ln_unsup = UNS_QUOTE;
                CH_STAR, CH_QMARK:    ln_unsup = UNS_WILDCARD;
                CH_TILDE:             ln_unsup = UNS_TILDE;
                CH_BACKSLASH:         ln_unsup = UNS_BACKSLASH;
                default: ;
            endcase
            if (it.ch != CH_SPACE) ln_nonspace = 1'b1;
            case (ln_phase)
                PH_LEAD: begin
                    if (it.ch != CH_SPACE) begin
                        if (is_sep(it.ch)) begin
                            between_tokens(it.ch, kind, start);
                        end else begin
                            kind     = KIND_CMD;
                            start    = 1'b1;
                            ln_phase = PH_CMD;
                        end
                    end
                end
                PH_CMD:     continue_word(it.ch, KIND_CMD, PH_CMD, 1'b0, kind, start);
                PH_ARG:     continue_word(it.ch, KIND_ARG, PH_ARG, 1'b0, kind, start);
                PH_INLEAD:  continue_word(it.ch, KIND_INFILE, PH_INFILE, 1'b1, kind, start);
                PH_INFILE:  continue_word(it.ch, KIND_INFILE, PH_INFILE, 1'b0, kind, start);
                PH_OUTLEAD: continue_word(it.ch, KIND_OUTFILE, PH_OUTFILE, 1'b1, kind, start);
                PH_OUTFILE: continue_word(it.ch, KIND_OUTFILE, PH_OUTFILE, 1'b0, kind, start);
                PH_ERR: ;
                default:    between_tokens(it.ch, kind, start);
            endcase
        end
        r             = '0;
        r.echo_byte   = it.vld ? it.ch : 8'h00;
        r.token_kind  = kind;
        r.token_start = start;
        if (it.last) begin
            // Report the line, then drop its state; piping survives the line end
            r.line_done        = 1'b1;
            r.parse_status     = (ln_err == ST_OK && !ln_nonspace) ? ST_EMPTY : ln_err;
            r.in_redirected    = ln_in;
            r.out_redirected   = ln_out;
            r.run_background   = ln_bg;
            r.unsupported_code = ln_unsup;
            line_outcomes[r.parse_status]++;
            lines_seen++;
            if (piping) piped_lines++;
            ln_phase    = PH_LEAD;
            ln_in       = 1'b0;
            ln_out      = 1'b0;
            ln_bg       = 1'b0;
            ln_err      = ST_OK;
            ln_unsup    = UNS_NONE;
            ln_nonspace = 1'b0;
        end
        return r;
    endfunction

    function automatic string fmt_result(input t_result r);
        return {$sformatf("byte=%02h kind=%0d start=%0b done=%0b ",
                          r.echo_byte, r.token_kind, r.token_start, r.line_done),
                $sformatf("status=%0d in=%0b out=%0b bg=%0b uns=%0d",
                          r.parse_status, r.in_redirected, r.out_redirected,
                          r.run_background, r.unsupported_code)};
    endfunction

    // ------------------------------------------------------------------
    // Driver: offer queued items, predict each one as it is accepted
    // ------------------------------------------------------------------
    always @(posedge clk) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else begin
            // The item held on the port goes in at this edge: predict it
            // before the next one overwrites the local copy.
            if (in_valid && !in_stall) begin
                expected_results.insert(expected_results.size(), predict_token(drv_item));
            end
            // Hold the payload while stalled; otherwise advance or idle
            if (!in_valid || !in_stall) begin
                if (pending_items.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    drv_item = pending_items.pop_front();
                    char_byte  <= drv_item.ch;
                    byte_valid <= drv_item.vld;
                    line_end   <= drv_item.last;
                    in_valid   <= 1'b1;
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: random stall on the result side, check every result taken
    // ------------------------------------------------------------------
    always @(posedge clk) begin
        out_stall <= ($urandom_range(99) < recv_idle_pct);
        if (rst_n && out_valid && !out_stall) begin
            seen_result = {echo_byte, token_kind, token_start, line_done, parse_status,
                           in_redirected, out_redirected, run_background, unsupported_code};
            results_checked++;
            if (expected_results.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("[%0t] unexpected result: %s", $realtime, fmt_result(seen_result));
            end else if (seen_result !== expected_results[0]) begin
                mismatch_count++;
                if (mismatch_count <= 10) begin
                    $display("[%0t] result mismatch", $realtime);
                    $display("    expected %s", fmt_result(expected_results[0]));
                    $display("    actual   %s", fmt_result(seen_result));
                end
                void'(expected_results.pop_front());
            end else begin
                void'(expected_results.pop_front());
            end
        end
    end

    // ------------------------------------------------------------------
    // Watchdog: give up if nothing moves on either channel for too long
    // ------------------------------------------------------------------
    always @(posedge clk) begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
            stuck_cycles <= 0;
        end else if (stuck_cycles >= STUCK_LIMIT) begin
            $display("[%0t] no progress for %0d cycles, %0d results outstanding",
                     $realtime, STUCK_LIMIT, expected_results.size());
            $display("** command_line_tokenizer_top: FAILED **");
            $finish;
        end else begin
            stuck_cycles <= stuck_cycles + 1;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers (no time passes in these)
    // ------------------------------------------------------------------
    task automatic add_item(input logic [7:0] ch, input logic vld, input logic last);
        pending_items.insert(pending_items.size(), '{ch: ch, vld: vld, last: last});
        if (vld || last) stim_items++;
        else ignored_items++;
    endtask

    // Byte for a word: mostly letters, some full-range bytes and unsupported characters
    function automatic logic [7:0] word_char();
        logic [7:0]  c;
        int unsigned pick;
        pick = $urandom_range(99);
        if (pick < 12) begin
            case ($urandom_range(5))
                0:       c = CH_DQUOTE;
                1:       c = CH_SQUOTE;
                2:       c = CH_STAR;
                3:       c = CH_QMARK;
                4:       c = CH_TILDE;
                default: c = CH_BACKSLASH;
            endcase
        end else if (pick < 40) begin
            c = 8'($urandom_range(255));
        end else begin
            c = 8'($urandom_range(8'h7A, 8'h61));
        end
        if (is_sep(c)) c = 8'h5F;
        return c;
    endfunction

    function automatic logic [7:0] sep_char();
        case ($urandom_range(3))
            0:       return CH_SPACE;
            1:       return CH_LT;
            2:       return CH_GT;
            default: return CH_AMP;
        endcase
    endfunction

    task automatic add_spaces(input int unsigned lo, input int unsigned hi);
        repeat ($urandom_range(hi, lo)) line_text.insert(line_text.size(), CH_SPACE);
    endtask

    task automatic add_word();
        repeat ($urandom_range(6, 1)) line_text.insert(line_text.size(), word_char());
    endtask

    // Redirect with a file name; now and then leave the name empty
    task automatic add_redirect(input logic [7:0] marker);
        add_spaces(0, 1);
        line_text.insert(line_text.size(), marker);
        add_spaces(0, 2);
        if ($urandom_range(99) < 90) add_word();
    endtask

    // Build one random line and queue it, with ignored items sprinkled in
    task automatic queue_line();
        int unsigned style;
        logic        closes_on_byte;
        line_text.delete();
        style = $urandom_range(99);
        if (style < 8) begin
            // blank or all-space line
            add_spaces(0, 3);
        end else if (style < 25) begin
            // broken line: separators and word bytes in any order
            repeat ($urandom_range(10, 1))
                line_text.insert(line_text.size(),
                                 ($urandom_range(1) == 0) ? sep_char() : word_char());
        end else begin
            // well-formed: command, arguments, redirects, background marker
            add_spaces(0, 2);
            add_word();
            repeat ($urandom_range(3)) begin
                add_spaces(1, 2);
                add_word();
            end
            if ($urandom_range(99) < 40) add_redirect(CH_LT);
            if ($urandom_range(99) < 40) add_redirect(CH_GT);
            if ($urandom_range(99) < 10) add_redirect(($urandom_range(1) == 0) ? CH_LT : CH_GT);
            if ($urandom_range(99) < 30) begin
                add_spaces(1, 2);
                add_word();
            end
            if ($urandom_range(99) < 25) begin
                add_spaces(0, 1);
                line_text.insert(line_text.size(), CH_AMP);
            end
            add_spaces(0, 1);
        end
        // End the line on its last byte, or with a separate empty marker
        closes_on_byte = (line_text.size() != 0) && ($urandom_range(1) == 1);
        for (int k = 0; k < line_text.size(); k++) begin
            if ($urandom_range(99) < 6) add_item(8'($urandom_range(255)), 1'b0, 1'b0);
            add_item(line_text[k], 1'b1, closes_on_byte && (k == line_text.size() - 1));
        end
        if (!closes_on_byte) add_item(8'($urandom_range(255)), 1'b0, 1'b1);
    endtask

    // ------------------------------------------------------------------
    // Timed helpers
    // ------------------------------------------------------------------
    // Hold until nothing is queued, offered or outstanding, then let the pipe settle
    task automatic wait_idle();
        @(negedge clk);
        while (pending_items.size() != 0 || in_valid || expected_results.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    // Write the piping register; only called with the block idle
    task automatic set_piping(input logic mode);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= mode;
        @(posedge clk);
        cfg_we    <= 1'b0;
        piping = mode;
        @(negedge clk);
    endtask

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial begin
        for (int s = 0; s < 8; s++) line_outcomes[s] = 0;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed lines, no piping
        set_piping(1'b0);
        add_item(8'hA5, 1'b0, 1'b1);               // line with no bytes at all
        add_item(CH_SPACE, 1'b1, 1'b1);            // line of spaces only
        add_item(8'h00, 1'b1, 1'b0);               // zero byte opens the command
        add_item(8'hFF, 1'b1, 1'b0);
        add_item(8'h5A, 1'b0, 1'b0);               // ignored item mid-line
        add_item(CH_STAR, 1'b1, 1'b0);
        add_item(CH_SPACE, 1'b1, 1'b0);
        add_item(CH_LT, 1'b1, 1'b0);
        add_item(CH_SPACE, 1'b1, 1'b0);
        add_item(CH_TILDE, 1'b1, 1'b0);            // input file name
        add_item(CH_GT, 1'b1, 1'b0);               // separator ends the file name
        add_item(CH_SQUOTE, 1'b1, 1'b0);           // output file name
        add_item(CH_AMP, 1'b1, 1'b0);
        add_item(CH_BACKSLASH, 1'b1, 1'b1);        // argument on the line-end item
        add_item(CH_LT, 1'b1, 1'b0);               // empty input file name ...
        add_item(CH_LT, 1'b1, 1'b0);               // ... then a second '<'
        add_item(CH_QMARK, 1'b1, 1'b0);            // after the error: code still moves
        add_item(CH_DQUOTE, 1'b1, 1'b1);
        add_item(CH_GT, 1'b1, 1'b0);
        add_item(8'h78, 1'b1, 1'b0);
        add_item(CH_GT, 1'b1, 1'b1);               // second '>'
        wait_idle();

        // Directed lines under piping: each redirect and '&' is an error
        set_piping(1'b1);
        add_item(8'h61, 1'b1, 1'b0);
        add_item(CH_LT, 1'b1, 1'b0);
        add_item(8'h62, 1'b1, 1'b1);
        add_item(CH_GT, 1'b1, 1'b1);
        add_item(8'h61, 1'b1, 1'b0);
        add_item(CH_AMP, 1'b1, 1'b1);
        wait_idle();

        // Random phases, alternating the piping setting
        for (int p = 0; p < 6; p++) begin
            int target;
            set_piping(p % 2 == 0);
            // one phase runs flat out on both sides
            send_idle_pct = (p == 2) ? 0 : 30;
            recv_idle_pct = (p == 2) ? 0 : 30;
            target = stim_items + PHASE_ITEMS;
            if (p == 3) begin
                // Sender holds half-way until every result is back
                while (stim_items < target - PHASE_ITEMS / 2) queue_line();
                wait_idle();
            end
            while (stim_items < target) queue_line();
            wait_idle();
        end

        repeat (8) @(negedge clk);
        $write("Run covered %0d items in %0d lines (%0d piped), ",
               stim_items, lines_seen, piped_lines);
        $display("%0d ignored items, %0d results checked", ignored_items, results_checked);
        $write("Line outcomes: ok %0d, empty %0d, redirect in pipe %0d, ",
               line_outcomes[ST_OK], line_outcomes[ST_EMPTY], line_outcomes[ST_REDIR_PIPE]);
        $display("second '<' %0d, second '>' %0d, '&' in pipe %0d; mismatches %0d",
                 line_outcomes[ST_SECOND_IN], line_outcomes[ST_SECOND_OUT],
                 line_outcomes[ST_BG_PIPE], mismatch_count);
        if (mismatch_count == 0) begin
            $display("** command_line_tokenizer_top: PASSED **");
        end else begin
            $display("** command_line_tokenizer_top: FAILED **");
        end
        $finish;
    end

endmodule
